>>> sv/nng_pkg.sv
// Shared types, constants and register codes of the nearest-neighbour gate.
package nng_pkg;

    // Frame length and position counter
    localparam int MAX_MEAS = 256;
    localparam int POS_W    = (MAX_MEAS > 1) ? $clog2(MAX_MEAS) : 1;
    localparam int IDX_W    = 8;

    // Field widths
    localparam int XY_W     = 20;
    localparam int COV_W    = 16;
    localparam int GATE_W   = 16;
    localparam int CFG_W    = 20;

    // Datapath widths
    localparam int D_W      = XY_W + 1;          // innovation dx, dy
    localparam int SQ_W     = 2 * D_W;           // dx*dx, dy*dy, dx*dy
    localparam int SQ_LO_W  = D_W;               // low half of a square
    localparam int SQ_HI_W  = SQ_W - SQ_LO_W;    // high half of a square
    localparam int COEF_W   = COV_W + 1;         // covariance or cross sum
    localparam int PH_W     = SQ_HI_W + COEF_W;
    localparam int PL_W     = SQ_LO_W + 1 + COEF_W;
    localparam int SCORE_W  = 61;
    localparam int PROD_W   = 2 * COV_W;
    localparam int DET_W    = PROD_W + 1;
    localparam int T_W      = GATE_W + PROD_W;
    localparam int LIM_SH   = 6;
    localparam int LIM_W    = T_W - LIM_SH;

    // Front pipeline depth and queue size
    localparam int NSTAGE   = 6;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    // Register index codes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PRED_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRED_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COV_XX = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COV_XY = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COV_YX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COV_YY = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GATE   = 3'd6;

    // Register reset values
    localparam logic signed [XY_W-1:0]  PRED_RESET     = '0;
    localparam logic signed [COV_W-1:0] COV_DIAG_RESET = 16'sd1024;
    localparam logic signed [COV_W-1:0] COV_OFF_RESET  = '0;
    localparam logic [GATE_W-1:0]       GATE_RESET     = 16'd37765;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX    = {1'b0, {(SCORE_W-1){1'b1}}};

    // Input word
    typedef struct packed {
        logic signed [XY_W-1:0] meas_x;
        logic signed [XY_W-1:0] meas_y;
        logic                   last_meas;
    } meas_t;

    // Result word
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] best_index;
    } result_t;

    // Frame position and end-of-frame mark of one measurement
    typedef struct packed {
        logic             eof;
        logic [POS_W-1:0] pos;
    } tag_t;

    // Classified measurement handed from front to back
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      pass;
        tag_t                      tag;
    } q_entry_t;

endpackage

>>> sv/nng_front.sv
// Front part: configuration registers, score pipeline and gate classification.
module nng_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [nng_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [nng_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  nng_pkg::meas_t                in_word,
    output logic                          q_wr_en,
    output nng_pkg::q_entry_t             q_wr_data,
    input  logic                          q_full
);
    import nng_pkg::*;

    // Configuration registers
    logic signed [XY_W-1:0]  pred_x_reg, pred_x_next;
    logic signed [XY_W-1:0]  pred_y_reg, pred_y_next;
    logic signed [COV_W-1:0] cov_xx_reg, cov_xx_next;
    logic signed [COV_W-1:0] cov_xy_reg, cov_xy_next;
    logic signed [COV_W-1:0] cov_yx_reg, cov_yx_next;
    logic signed [COV_W-1:0] cov_yy_reg, cov_yy_next;
    logic [GATE_W-1:0]       gate_reg, gate_next;

    // Derived gate terms
    logic signed [PROD_W-1:0] p_xx_yy, p_xy_yx;
    logic signed [DET_W-1:0]  det_reg, det_next;
    logic                     det_pos_reg, det_pos_next;
    logic [T_W-1:0]           gate_det;
    logic [LIM_W-1:0]         lim_reg, lim_next;
    logic signed [COEF_W-1:0] csum_reg, csum_next;
    logic signed [SCORE_W-1:0] lim_ext;

    // Pipeline control
    logic                adv;
    logic                accept;
    logic                eof_in;
    logic [POS_W-1:0]    count_reg, count_next;
    logic [NSTAGE-1:0]   valid_reg, valid_next;
    tag_t                tag_reg [NSTAGE];
    tag_t                tag_in;

    // Stage data
    logic signed [D_W-1:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic signed [SQ_W-1:0]    sq_xx_reg, sq_xx_next;
    logic signed [SQ_W-1:0]    sq_yy_reg, sq_yy_next;
    logic signed [SQ_W-1:0]    sq_xy_reg, sq_xy_next;
    logic signed [SQ_HI_W-1:0] hi_xx, hi_yy, hi_xy;
    logic signed [SQ_LO_W:0]   lo_xx, lo_yy, lo_xy;
    logic signed [COEF_W-1:0]  coef_xx, coef_yy;
    logic signed [PH_W-1:0]    ph_xx_reg, ph_xx_next, ph_yy_reg, ph_yy_next;
    logic signed [PH_W-1:0]    ph_xy_reg, ph_xy_next;
    logic signed [PL_W-1:0]    pl_xx_reg, pl_xx_next, pl_yy_reg, pl_yy_next;
    logic signed [PL_W-1:0]    pl_xy_reg, pl_xy_next;
    logic signed [SCORE_W-1:0] term_xx_reg, term_xx_next, term_yy_reg, term_yy_next;
    logic signed [SCORE_W-1:0] term_xy_reg, term_xy_next;
    logic signed [SCORE_W-1:0] sum_reg, sum_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic                      pass_reg, pass_next;

    // Decode register writes
    always_comb
    begin
        pred_x_next = pred_x_reg;
        pred_y_next = pred_y_reg;
        cov_xx_next = cov_xx_reg;
        cov_xy_next = cov_xy_reg;
        cov_yx_next = cov_yx_reg;
        cov_yy_next = cov_yy_reg;
        gate_next   = gate_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PRED_X: pred_x_next = cfg_wdata[XY_W-1:0];
                REG_PRED_Y: pred_y_next = cfg_wdata[XY_W-1:0];
                REG_COV_XX: cov_xx_next = cfg_wdata[COV_W-1:0];
                REG_COV_XY: cov_xy_next = cfg_wdata[COV_W-1:0];
                REG_COV_YX: cov_yx_next = cfg_wdata[COV_W-1:0];
                REG_COV_YY: cov_yy_next = cfg_wdata[COV_W-1:0];
                REG_GATE:   gate_next   = cfg_wdata[GATE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_x_reg <= PRED_RESET;
            pred_y_reg <= PRED_RESET;
            cov_xx_reg <= COV_DIAG_RESET;
            cov_xy_reg <= COV_OFF_RESET;
            cov_yx_reg <= COV_OFF_RESET;
            cov_yy_reg <= COV_DIAG_RESET;
            gate_reg   <= GATE_RESET;
        end
        else
        begin
            pred_x_reg <= pred_x_next;
            pred_y_reg <= pred_y_next;
            cov_xx_reg <= cov_xx_next;
            cov_xy_reg <= cov_xy_next;
            cov_yx_reg <= cov_yx_next;
            cov_yy_reg <= cov_yy_next;
            gate_reg   <= gate_next;
        end
    end

    // Track determinant, gate limit and cross sum in registers behind the configuration registers
    always_comb
    begin
        p_xx_yy      = cov_xx_reg * cov_yy_reg;
        p_xy_yx      = cov_xy_reg * cov_yx_reg;
        det_next     = DET_W'(p_xx_yy) - DET_W'(p_xy_yx);
        det_pos_next = !det_reg[DET_W-1] && (det_reg != '0);
        gate_det     = gate_reg * det_reg[PROD_W-1:0];
        lim_next     = LIM_W'((gate_det + T_W'(63)) >> LIM_SH);
        csum_next    = COEF_W'(cov_xy_reg) + COEF_W'(cov_yx_reg);
        lim_ext      = $signed(SCORE_W'(lim_reg));
    end

    always_ff @(posedge clk)
    begin
        det_reg     <= det_next;
        det_pos_reg <= det_pos_next;
        lim_reg     <= lim_next;
        csum_reg    <= csum_next;
    end

    // Advance the whole pipeline unless the tail word cannot enter the queue
    assign adv      = !valid_reg[NSTAGE-1] || !q_full;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign eof_in   = in_word.last_meas || (count_reg == POS_W'(MAX_MEAS - 1));
    assign tag_in   = '{eof: eof_in, pos: count_reg};

    // Count frame positions
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = eof_in ? '0 : count_reg + 1'b1;
        end
        valid_next = adv ? {valid_reg[NSTAGE-2:0], accept} : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Score datapath: innovation, squares, partial products, terms, sum, compare
    always_comb
    begin
        dx_next    = D_W'(in_word.meas_x) - D_W'(pred_x_reg);
        dy_next    = D_W'(in_word.meas_y) - D_W'(pred_y_reg);

        sq_xx_next = dx_reg * dx_reg;
        sq_yy_next = dy_reg * dy_reg;
        sq_xy_next = dx_reg * dy_reg;

        hi_xx      = sq_xx_reg[SQ_W-1:SQ_LO_W];
        hi_yy      = sq_yy_reg[SQ_W-1:SQ_LO_W];
        hi_xy      = sq_xy_reg[SQ_W-1:SQ_LO_W];
        lo_xx      = $signed({1'b0, sq_xx_reg[SQ_LO_W-1:0]});
        lo_yy      = $signed({1'b0, sq_yy_reg[SQ_LO_W-1:0]});
        lo_xy      = $signed({1'b0, sq_xy_reg[SQ_LO_W-1:0]});
        // dx^2 weighs with cov_yy, dy^2 with cov_xx
        coef_xx    = COEF_W'(cov_yy_reg);
        coef_yy    = COEF_W'(cov_xx_reg);
        ph_xx_next = hi_xx * coef_xx;
        ph_yy_next = hi_yy * coef_yy;
        ph_xy_next = hi_xy * csum_reg;
        pl_xx_next = lo_xx * coef_xx;
        pl_yy_next = lo_yy * coef_yy;
        pl_xy_next = lo_xy * csum_reg;

        term_xx_next = (SCORE_W'(ph_xx_reg) <<< SQ_LO_W) + SCORE_W'(pl_xx_reg);
        term_yy_next = (SCORE_W'(ph_yy_reg) <<< SQ_LO_W) + SCORE_W'(pl_yy_reg);
        term_xy_next = (SCORE_W'(ph_xy_reg) <<< SQ_LO_W) + SCORE_W'(pl_xy_reg);

        sum_next   = term_xx_reg - term_xy_reg + term_yy_reg;

        score_next = sum_reg;
        pass_next  = det_pos_reg && (sum_reg < lim_ext);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            sq_xx_reg   <= sq_xx_next;
            sq_yy_reg   <= sq_yy_next;
            sq_xy_reg   <= sq_xy_next;
            ph_xx_reg   <= ph_xx_next;
            ph_yy_reg   <= ph_yy_next;
            ph_xy_reg   <= ph_xy_next;
            pl_xx_reg   <= pl_xx_next;
            pl_yy_reg   <= pl_yy_next;
            pl_xy_reg   <= pl_xy_next;
            term_xx_reg <= term_xx_next;
            term_yy_reg <= term_yy_next;
            term_xy_reg <= term_xy_next;
            sum_reg     <= sum_next;
            score_reg   <= score_next;
            pass_reg    <= pass_next;
            tag_reg[0]  <= tag_in;
            for (int i = 1; i < NSTAGE; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // Hand the classified word to the queue
    assign q_wr_en   = valid_reg[NSTAGE-1] && !q_full;
    assign q_wr_data = '{score: score_reg, pass: pass_reg, tag: tag_reg[NSTAGE-1]};

endmodule

>>> sv/nng_queue.sv
// Short queue of classified measurements between front and back.
module nng_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  nng_pkg::q_entry_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output nng_pkg::q_entry_t rd_data,
    output logic              not_empty
);
    import nng_pkg::*;

    q_entry_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    // Move pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> not_empty)
        else $error("queue read while empty");

endmodule

>>> sv/nng_back.sv
// Back part: running minimum over passing scores and the result register.
module nng_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  nng_pkg::q_entry_t q_rd_data,
    output logic              q_rd_en,
    output logic              out_valid,
    input  logic              out_stall,
    output nng_pkg::result_t  out_word
);
    import nng_pkg::*;

    logic signed [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [POS_W-1:0]          best_pos_reg, best_pos_next;
    logic                      any_found_reg, any_found_next;
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_word_reg, out_word_next;
    logic                      upd;
    logic                      pop;
    logic                      found;
    logic [POS_W-1:0]          win_pos;

    // Take a word unless it ends a frame and the result register is still held
    assign pop = q_valid && (!q_rd_data.tag.eof || !out_valid_reg || !out_stall);
    assign upd = q_rd_data.pass &&
                 (!any_found_reg || (q_rd_data.score < best_score_reg));
    assign found   = any_found_reg || upd;
    assign win_pos = upd ? q_rd_data.tag.pos : best_pos_reg;

    // Update the running minimum and emit on end of frame
    always_comb
    begin
        best_score_next = best_score_reg;
        best_pos_next   = best_pos_reg;
        any_found_next  = any_found_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (pop)
        begin
            if (q_rd_data.tag.eof)
            begin
                out_valid_next   = 1'b1;
                out_word_next    = '{found: found,
                                     best_index: found ? IDX_W'(win_pos) : '0};
                best_score_next  = SCORE_MAX;
                best_pos_next    = '0;
                any_found_next   = 1'b0;
            end
            else if (upd)
            begin
                best_score_next = q_rd_data.score;
                best_pos_next   = q_rd_data.tag.pos;
                any_found_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= SCORE_MAX;
            best_pos_reg   <= '0;
            any_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_pos_reg   <= best_pos_next;
            any_found_reg  <= any_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign q_rd_en   = pop;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_eof_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_rd_data.tag.eof) |=> out_valid_reg)
        else $error("end of frame popped without a result");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.found) |-> (out_word_reg.best_index == '0))
        else $error("nonzero index on empty gate result");

    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !any_found_reg |-> (best_pos_reg == '0))
        else $error("best position set without a passing score");

endmodule

>>> sv/nearest_neighbour_gating_top.sv
// out_valid rises once a frame's last word has passed the pipeline, queue and result register.
// Throughput: one measurement word per cycle; the six-stage score pipeline and the
// four-word queue stall only when the result register is held by out_stall at frame end.
// After a write, the gate limit settles through the determinant and limit registers.
// Reset: asynchronous, active low; registers return to their reset values, frame state clears.
// No clearing pass after reset; words are accepted as soon as reset is released.
module nearest_neighbour_gating_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [nng_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [nng_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  nng_pkg::meas_t                in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output nng_pkg::result_t              out_word
);
    import nng_pkg::*;

    logic     q_wr_en;
    q_entry_t q_wr_data;
    logic     q_full;
    logic     q_rd_en;
    q_entry_t q_rd_data;
    logic     q_valid;

    // Classify measurements
    nng_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data),
        .q_full    (q_full)
    );

    // Buffer classified words
    nng_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr_en),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_rd_en),
        .rd_data   (q_rd_data),
        .not_empty (q_valid)
    );

    // Keep the nearest passing measurement and report per frame
    nng_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rd_data (q_rd_data),
        .q_rd_en   (q_rd_en),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

>>> verif/nearest_neighbour_gating_top_test.sv
// Self-checking testbench for the nearest-neighbour gate: random frames checked against a predictor.
`timescale 1ns / 100ps

module nearest_neighbour_gating_top_test;
    import nng_pkg::*;

    localparam int TOTAL_WORDS    = 950;
    localparam int DRAIN_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 3;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    meas_t                in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    result_t              out_word;

    // Track registers as the block should hold them
    logic signed [XY_W-1:0]  trk_pred_x;
    logic signed [XY_W-1:0]  trk_pred_y;
    logic signed [COV_W-1:0] trk_cov_xx;
    logic signed [COV_W-1:0] trk_cov_xy;
    logic signed [COV_W-1:0] trk_cov_yx;
    logic signed [COV_W-1:0] trk_cov_yy;
    logic [GATE_W-1:0]       trk_gate;

    // Running frame state of the gate
    longint      best_score;
    int unsigned best_pos;
    bit          any_found;
    int unsigned meas_count;

    meas_t   pending_words[$];
    result_t frame_results[$];

    bit steady = 1'b0;
    int errors         = 0;
    int words_queued   = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;

    nearest_neighbour_gating_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int span_pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Pick a range end, zero or anything in between
    function automatic int corner_pick(int lo, int hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return 0;
            default: return span_pick(lo, hi);
        endcase
    endfunction

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 16);
    endfunction

    function automatic void clear_frame();
        best_score = (longint'(1) << 60) - 1;
        best_pos   = 0;
        any_found  = 1'b0;
        meas_count = 0;
    endfunction

    // Score one word against the track and close the frame where it ends
    function automatic void gate_measurement(input meas_t w);
        longint      dx, dy, sxx, sxy, syx, syy, det, score, lim;
        int unsigned pos;
        result_t     res;
        dx  = longint'(w.meas_x) - longint'(trk_pred_x);
        dy  = longint'(w.meas_y) - longint'(trk_pred_y);
        sxx = longint'(trk_cov_xx);
        sxy = longint'(trk_cov_xy);
        syx = longint'(trk_cov_yx);
        syy = longint'(trk_cov_yy);
        det = sxx * syy - sxy * syx;
        pos = meas_count;
        if (det > 0)
        begin
            score = syy * (dx * dx) - (sxy + syx) * (dx * dy) + sxx * (dy * dy);
            // compare score*64 against gate*det without losing bits
            lim = (longint'(trk_gate) * det + 63) / 64;
            if (score < lim && (!any_found || score < best_score))
            begin
                best_score = score;
                best_pos   = pos;
                any_found  = 1'b1;
            end
        end
        if (w.last_meas || pos >= MAX_MEAS - 1)
        begin
            res.found      = any_found;
            res.best_index = any_found ? best_pos[IDX_W-1:0] : '0;
            frame_results.insert(frame_results.size(), res);
            clear_frame();
        end
        else
            meas_count = pos + 1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic push_word(input int x, input int y, input bit last);
        meas_t w;
        w.meas_x    = x[XY_W-1:0];
        w.meas_y    = y[XY_W-1:0];
        w.last_meas = last;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    // Hold until every word is taken and every result has come back
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || frame_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        case (idx)
            REG_PRED_X: trk_pred_x = value[XY_W-1:0];
            REG_PRED_Y: trk_pred_y = value[XY_W-1:0];
            REG_COV_XX: trk_cov_xx = value[COV_W-1:0];
            REG_COV_XY: trk_cov_xy = value[COV_W-1:0];
            REG_COV_YX: trk_cov_yx = value[COV_W-1:0];
            REG_COV_YY: trk_cov_yy = value[COV_W-1:0];
            REG_GATE:   trk_gate   = value[GATE_W-1:0];
            default: ;
        endcase
    endtask

    // Drain the pipeline, load a full track setting, let the gate limit settle
    task automatic apply_setting(input int px, input int py, input int cxx, input int cxy,
                                 input int cyx, input int cyy, input int gate);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_PRED_X, px);
        write_reg(REG_PRED_Y, py);
        write_reg(REG_COV_XX, cxx);
        write_reg(REG_COV_XY, cxy);
        write_reg(REG_COV_YX, cyx);
        write_reg(REG_COV_YY, cyy);
        write_reg(REG_GATE, gate);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        settings_used++;
    endtask

    task automatic random_setting(input bit corner);
        int cxx, cxy;
        if (corner)
            apply_setting(corner_pick(-524288, 524287), corner_pick(-524288, 524287),
                          corner_pick(-32768, 32767), corner_pick(-32768, 32767),
                          corner_pick(-32768, 32767), corner_pick(-32768, 32767),
                          corner_pick(0, 65535));
        else
        begin
            // plausible track: positive diagonal, small and mostly symmetric cross terms
            cxx = span_pick(256, 8192);
            cxy = span_pick(-512, 512);
            apply_setting(span_pick(-524288, 524287), span_pick(-524288, 524287),
                          cxx, cxy, ($urandom_range(3) == 0) ? span_pick(-512, 512) : cxy,
                          span_pick(256, 8192), span_pick(4096, 65535));
        end
    endtask

    // Queue one frame; near words fall around the predicted position
    task automatic queue_frame(input int len, input int near_pct, input int near_at,
                               input bit mark_last);
        int  span, x, y;
        bit  near;
        for (int i = 0; i < len; i++)
        begin
            near = (i == near_at) || ($urandom_range(99) < near_pct);
            if (near)
            begin
                span = (i == near_at) ? 256 : corner_pick(256, 4096);
                x = int'(trk_pred_x) + span_pick(-span, span);
                y = int'(trk_pred_y) + span_pick(-span, span);
            end
            else
            begin
                x = $urandom();
                y = $urandom();
            end
            push_word(x, y, mark_last && i == len - 1);
        end
    endtask

    // Present queued words, hold a stalled word, idle at random
    always @(posedge clk)
    begin : drive_words
        logic busy;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            busy = in_valid && in_stall;
            if (in_valid && !in_stall)
            begin
                gate_measurement(in_word);
                words_accepted++;
            end
            if (!busy)
            begin
                if (pending_words.size() != 0 && !idle_now())
                begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (frame_results.size() == 0)
                    report_mismatch("unexpected result, best_index", out_word.best_index, -1);
                else
                begin
                    want = frame_results.pop_front();
                    if (out_word.found !== want.found)
                        report_mismatch("found", out_word.found, want.found);
                    if (out_word.best_index !== want.best_index)
                        report_mismatch("best_index", out_word.best_index, want.best_index);
                end
            end
            out_stall <= idle_now();
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run_stimulus
        int phase;
        int frames;
        int len;
        trk_pred_x = PRED_RESET;
        trk_pred_y = PRED_RESET;
        trk_cov_xx = COV_DIAG_RESET;
        trk_cov_xy = COV_OFF_RESET;
        trk_cov_yx = COV_OFF_RESET;
        trk_cov_yy = COV_DIAG_RESET;
        trk_gate   = GATE_RESET;
        clear_frame();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: single hit, then field extremes, a tie and a miss
        push_word(0, 0, 1);
        push_word(524287, 524287, 0);
        push_word(-524288, -524288, 0);
        push_word(768, 0, 0);
        push_word(0, 512, 0);
        push_word(0, -512, 0);
        push_word(1000, 1000, 1);
        push_word(524287, -524288, 1);

        // covariance with det > 0 but negative scores: farthest word wins
        apply_setting(0, 0, -1024, 0, 0, -1024, 37765);
        push_word(256, 0, 0);
        push_word(0, 0, 0);
        push_word(512, 512, 1);

        // det of zero: nothing may pass even at the prediction
        apply_setting(0, 0, 0, 0, 0, 1024, 65535);
        push_word(0, 0, 1);
        push_word(5, 5, 1);

        // register extremes with a wide gate
        apply_setting(524287, -524288, 32767, -32768, 32767, 32767, 65535);
        push_word(524287, -524288, 0);
        push_word(-524288, 524287, 0);
        push_word(524000, -524000, 1);

        // zero gate: a zero score does not pass
        apply_setting(-524288, 524287, 1024, 0, 0, 1024, 0);
        push_word(-524288, 524287, 1);
        push_word(0, 0, 1);

        // random settings and frames
        phase = 0;
        while (words_queued < TOTAL_WORDS)
        begin
            random_setting(phase % 3 == 2);
            steady = (phase >= 4 && phase < 8);
            if (phase == 6)
            begin
                // overlong frame: position 255 closes it, only that word is near
                queue_frame(260, 0, 255, 1'b1);
                wait_drained();
            end
            frames = span_pick(1, 6);
            repeat (frames)
            begin
                len = ($urandom_range(9) == 0) ? span_pick(20, 60) : span_pick(1, 12);
                queue_frame(len, 75, -1, 1'b1);
                if ($urandom_range(3) == 0)
                    wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d measurement words and %0d frame results", words_accepted,
                 results_seen);
        $display("over %0d track settings, including degenerate covariance and zero gate",
                 settings_used);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
